### src/hufftw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufftw_pkg
// Shared types and constants for the tree-walk decoder and its checker.
// ----------------------------------------------------------------------------
package hufftw_pkg;

    localparam int TABLE_NODES = 512;
    localparam int TBL_ADDR_W  = $clog2(TABLE_NODES);
    localparam int NODE_IDX_W  = 9;
    localparam int SYM_W       = 8;
    localparam int COUNT_W     = 32;
    localparam int BYTE_BITS   = 8;
    localparam int BIT_CNT_W   = $clog2(BYTE_BITS + 1);
    localparam int CMD_W       = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CODE  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                  leaf;
        logic [SYM_W-1:0]      symbol;
        logic [NODE_IDX_W-1:0] zero_child;
        logic [NODE_IDX_W-1:0] one_child;
    } node_t;

endpackage

### src/huffman_tree_walk_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Decodes a Huffman bitstream at most one code bit per cycle over a node table RAM; output stalls hold the walk.
// ----------------------------------------------------------------------------
// Load and start transactions are accepted in ST_IDLE and leave the input ready.
// A code byte reads the root, then the current node, walks its code bits one by one,
// resolves the last child read and drains in ST_FLUSH; a leaf root right after a leaf
// child retries that bit, and output stalls hold the walk.
// A symbol waits for the next one or the end of its byte.
// rst_n clears control state, walk position and counts; the table is not cleared.
module huffman_tree_walk_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [hufftw_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [8:0] node_index, [9] node_is_leaf, [17:10] node_symbol,
    // [26:18] zero_child, [35:27] one_child, [43:36] code_byte
    input  logic [hufftw_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] cmd
    input  logic [hufftw_pkg::CMD_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] out_symbol
    output logic [hufftw_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                m_tlast,
    // [0] stream_done
    output logic                                m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_POS,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_CUR,
        Q_CHILD
    } qmode_t;

    localparam int IDX_CMP_W = hufftw_pkg::NODE_IDX_W + 1;

    // input field unpacking
    logic [hufftw_pkg::NODE_IDX_W-1:0] in_node_index;
    logic                              in_node_is_leaf;
    logic [hufftw_pkg::SYM_W-1:0]      in_node_symbol;
    logic [hufftw_pkg::NODE_IDX_W-1:0] in_zero_child;
    logic [hufftw_pkg::NODE_IDX_W-1:0] in_one_child;
    logic [hufftw_pkg::BYTE_BITS-1:0]  in_code_byte;
    hufftw_pkg::cmd_t                  in_cmd;

    assign in_node_index   = s_tdata[8:0];
    assign in_node_is_leaf = s_tdata[9];
    assign in_node_symbol  = s_tdata[17:10];
    assign in_zero_child   = s_tdata[26:18];
    assign in_one_child    = s_tdata[35:27];
    assign in_code_byte    = s_tdata[43:36];
    assign in_cmd          = hufftw_pkg::cmd_t'(s_tuser);

    // node table
    hufftw_pkg::node_t                  mem [hufftw_pkg::TABLE_NODES];
    hufftw_pkg::node_t                  ram_q;
    logic                               rd_en;
    logic [hufftw_pkg::TBL_ADDR_W-1:0]  rd_addr;
    logic                               wr_en;

    // registers
    state_t                             state_reg, state_next;
    qmode_t                             q_reg, q_next;
    logic [hufftw_pkg::COUNT_W-1:0]     count_cfg_reg, count_cfg_next;
    logic [hufftw_pkg::COUNT_W-1:0]     left_reg, left_next;
    logic [hufftw_pkg::NODE_IDX_W-1:0]  pos_reg, pos_next;
    logic [hufftw_pkg::NODE_IDX_W-1:0]  child_reg, child_next;
    hufftw_pkg::node_t                  root_reg, root_next;
    hufftw_pkg::node_t                  cur_reg, cur_next;
    logic [hufftw_pkg::BYTE_BITS-1:0]   shift_reg, shift_next;
    logic [hufftw_pkg::BIT_CNT_W-1:0]   bits_reg, bits_next;
    logic                               hold_valid_reg, hold_valid_next;
    logic [hufftw_pkg::SYM_W-1:0]       hold_sym_reg, hold_sym_next;
    logic                               hold_done_reg, hold_done_next;
    logic                               out_valid_reg, out_valid_next;
    logic [hufftw_pkg::SYM_W-1:0]       out_sym_reg, out_sym_next;
    logic                               out_last_reg, out_last_next;
    logic                               out_done_reg, out_done_next;

    // walk datapath
    logic                               adv;
    logic                               emit;
    logic [hufftw_pkg::SYM_W-1:0]       emit_sym;
    logic                               push;
    logic                               push_last;
    logic                               emit_r;
    logic                               zero_after;
    hufftw_pkg::node_t                  c_node;
    logic [hufftw_pkg::NODE_IDX_W-1:0]  child;
    logic                               child_bad;

    assign wr_en = (state_reg == ST_IDLE) && s_tvalid && (in_cmd == hufftw_pkg::CMD_LOAD)
                   && (IDX_CMP_W'(in_node_index) < IDX_CMP_W'(hufftw_pkg::TABLE_NODES));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[in_node_index[hufftw_pkg::TBL_ADDR_W-1:0]] <=
                {in_node_is_leaf, in_node_symbol, in_zero_child, in_one_child};
        end
        if (rd_en)
        begin
            ram_q <= mem[rd_addr];
        end
    end

    assign adv    = !out_valid_reg || m_tready;
    assign emit_r = (q_reg == Q_CHILD) && ram_q.leaf;

    always_comb
    begin
        case (q_reg)
            Q_CUR:   c_node = ram_q;
            Q_CHILD: c_node = ram_q.leaf ? root_reg : ram_q;
            default: c_node = cur_reg;
        endcase
    end

    assign zero_after = emit_r ? (left_reg == hufftw_pkg::COUNT_W'(1))
                               : (left_reg == '0);
    assign child      = shift_reg[0] ? c_node.one_child : c_node.zero_child;
    assign child_bad  = IDX_CMP_W'(child) >= IDX_CMP_W'(hufftw_pkg::TABLE_NODES);

    always_comb
    begin
        state_next      = state_reg;
        q_next          = q_reg;
        count_cfg_next  = count_cfg_reg;
        left_next       = left_reg;
        pos_next        = pos_reg;
        child_next      = child_reg;
        root_next       = root_reg;
        cur_next        = cur_reg;
        shift_next      = shift_reg;
        bits_next       = bits_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_done_next  = hold_done_reg;
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        rd_en           = 1'b0;
        rd_addr         = child[hufftw_pkg::TBL_ADDR_W-1:0];
        emit            = 1'b0;
        emit_sym        = ram_q.symbol;
        push            = 1'b0;
        push_last       = 1'b0;

        if (cfg_wr_en)
        begin
            count_cfg_next = cfg_wr_data;
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_cmd)
                        hufftw_pkg::CMD_CODE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            shift_next = in_code_byte;
                            bits_next  = hufftw_pkg::BIT_CNT_W'(hufftw_pkg::BYTE_BITS);
                            state_next = ST_RD_POS;
                        end
                        hufftw_pkg::CMD_START:
                        begin
                            pos_next  = '0;
                            left_next = count_cfg_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RD_POS:
            begin
                root_next  = ram_q;
                rd_en      = 1'b1;
                rd_addr    = pos_reg[hufftw_pkg::TBL_ADDR_W-1:0];
                q_next     = Q_CUR;
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                if (adv)
                begin
                    rd_en  = 1'b1;
                    q_next = Q_NONE;
                    // resolve the child read of the previous bit
                    if (emit_r)
                    begin
                        emit     = 1'b1;
                        emit_sym = ram_q.symbol;
                        pos_next = '0;
                    end
                    else if (q_reg == Q_CHILD)
                    begin
                        pos_next = child_reg;
                    end
                    cur_next = c_node;

                    if ((bits_reg != '0) && !zero_after)
                    begin
                        if (c_node.leaf)
                        begin
                            // second symbol in one cycle: this bit is retried on a later walk step
                            if (!emit_r)
                            begin
                                emit       = 1'b1;
                                emit_sym   = c_node.symbol;
                                pos_next   = '0;
                                cur_next   = root_reg;
                                shift_next = shift_reg >> 1;
                                bits_next  = bits_reg - hufftw_pkg::BIT_CNT_W'(1);
                            end
                        end
                        else if (child_bad)
                        begin
                            pos_next   = '0;
                            cur_next   = root_reg;
                            shift_next = shift_reg >> 1;
                            bits_next  = bits_reg - hufftw_pkg::BIT_CNT_W'(1);
                        end
                        else
                        begin
                            child_next = child;
                            q_next     = Q_CHILD;
                            shift_next = shift_reg >> 1;
                            bits_next  = bits_reg - hufftw_pkg::BIT_CNT_W'(1);
                        end
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (adv)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            push            = hold_valid_reg;
            hold_valid_next = 1'b1;
            hold_sym_next   = emit_sym;
            hold_done_next  = (left_reg == hufftw_pkg::COUNT_W'(1));
            left_next       = left_reg - hufftw_pkg::COUNT_W'(1);
        end

        if (push)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = hold_sym_reg;
            out_last_next  = push_last;
            out_done_next  = hold_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            q_reg          <= Q_NONE;
            count_cfg_reg  <= '0;
            left_reg       <= '0;
            pos_reg        <= '0;
            child_reg      <= '0;
            root_reg       <= '0;
            cur_reg        <= '0;
            shift_reg      <= '0;
            bits_reg       <= '0;
            hold_valid_reg <= 1'b0;
            hold_sym_reg   <= '0;
            hold_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sym_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            q_reg          <= q_next;
            count_cfg_reg  <= count_cfg_next;
            left_reg       <= left_next;
            pos_reg        <= pos_next;
            child_reg      <= child_next;
            root_reg       <= root_next;
            cur_reg        <= cur_next;
            shift_reg      <= shift_next;
            bits_reg       <= bits_next;
            hold_valid_reg <= hold_valid_next;
            hold_sym_reg   <= hold_sym_next;
            hold_done_reg  <= hold_done_next;
            out_valid_reg  <= out_valid_next;
            out_sym_reg    <= out_sym_next;
            out_last_reg   <= out_last_next;
            out_done_reg   <= out_done_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

### src/hufftw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufftw_checker
// Port-level assertions for the tree-walk decoder, bound to the decoder module.
// ----------------------------------------------------------------------------
module hufftw_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [hufftw_pkg::CMD_W-1:0]        s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [hufftw_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                                m_tlast,
    input logic                                m_tuser
);

    // stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
        && $stable(m_tlast) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // the symbol that ends the stream also ends its code byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("stream_done without last_of_byte");

    // a code byte keeps the input busy while the walk runs
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == hufftw_pkg::CMD_CODE) |=> !s_tready)
        else $error("input ready during code byte walk");

    // load, start and unknown commands leave the input ready
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != hufftw_pkg::CMD_CODE) |=> s_tready)
        else $error("non-code transaction stalled the input");

endmodule

bind huffman_tree_walk_decoder hufftw_checker u_hufftw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for huffman_tree_walk_decoder. A queue-fed driver sends
// node loads, stream starts and code bytes. An in-bench tree walker predicts
// every decoded symbol. A monitor compares each output transaction with the
// oldest prediction. Both sides insert random gaps, and the receiver stalls
// once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [hufftw_pkg::CMD_W-1:0] CMD_RSVD = 2'd3;
    localparam int RANDOM_ITEMS   = 395;
    localparam int MAX_LEAVES     = 24;
    localparam int SETTLE_CYCLES  = 32;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int HOLD_PHASE     = 6;

    typedef logic [hufftw_pkg::NODE_IDX_W-1:0] idx_t;
    typedef logic [hufftw_pkg::SYM_W-1:0]      sym_t;

    typedef struct {
        logic [hufftw_pkg::CMD_W-1:0] cmd;
        idx_t                         node_index;
        logic                         leaf;
        sym_t                         symbol;
        idx_t                         zero_child;
        idx_t                         one_child;
        sym_t                         code_byte;
    } dec_item_t;

    typedef struct {
        sym_t sym;
        logic last;
        logic done;
    } sym_exp_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [hufftw_pkg::COUNT_W-1:0]      cfg_wr_data = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [hufftw_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic [hufftw_pkg::CMD_W-1:0]        s_tuser = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [hufftw_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                                m_tlast;
    logic                                m_tuser;

    // predictor state
    hufftw_pkg::node_t                   tree_mem [0:hufftw_pkg::TABLE_NODES-1];
    idx_t                                walk_pos = '0;
    logic [hufftw_pkg::COUNT_W-1:0]      syms_left = '0;
    logic [hufftw_pkg::COUNT_W-1:0]      count_cfg = '0;

    dec_item_t item_q [$];
    sym_exp_t  sym_q [$];
    dec_item_t on_wire;

    bit slot_loaded [0:hufftw_pkg::TABLE_NODES-1];
    int loaded_slots [$];

    int  random_items = 0;
    int  mismatches = 0;
    int  send_gap = 0;
    int  rx_wait = 0;
    bit  no_gaps = 1'b0;
    bit  rx_hold_req = 1'b0;
    logic rx_hold = 1'b0;
    logic offer;

    huffman_tree_walk_decoder uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // applies one transaction to the predictor and queues its expected symbols, in order
    task automatic walk_tree(input dec_item_t it);
        hufftw_pkg::node_t cur;
        hufftw_pkg::node_t nxt;
        idx_t              next_pos;
        sym_exp_t          byte_syms [0:hufftw_pkg::BYTE_BITS-1];
        sym_t              leaf_sym;
        bit                emit;
        int                n;
        n = 0;
        if (it.cmd == hufftw_pkg::CMD_LOAD)
        begin
            tree_mem[it.node_index] = {it.leaf, it.symbol, it.zero_child, it.one_child};
        end
        else if (it.cmd == hufftw_pkg::CMD_START)
        begin
            walk_pos  = '0;
            syms_left = count_cfg;
        end
        else if (it.cmd == hufftw_pkg::CMD_CODE)
        begin
            for (int b = 0; b < hufftw_pkg::BYTE_BITS; b++)
            begin
                if (syms_left == 0)
                    break;
                emit = 1'b0;
                cur  = tree_mem[walk_pos];
                if (cur.leaf)
                begin
                    leaf_sym = cur.symbol;
                    emit     = 1'b1;
                    walk_pos = '0;
                end
                else
                begin
                    next_pos = it.code_byte[b] ? cur.one_child : cur.zero_child;
                    nxt      = tree_mem[next_pos];
                    if (nxt.leaf)
                    begin
                        leaf_sym = nxt.symbol;
                        emit     = 1'b1;
                        walk_pos = '0;
                    end
                    else
                    begin
                        walk_pos = next_pos;
                    end
                end
                if (emit)
                begin
                    syms_left    = syms_left - 1;
                    byte_syms[n] = '{leaf_sym, 1'b0, syms_left == 0};
                    n++;
                end
            end
            if (n > 0)
                byte_syms[n-1].last = 1'b1;
            for (int k = 0; k < n; k++)
                sym_q.push_back(byte_syms[k]);
        end
    endtask

    task automatic queue_load(input int idx, input logic leaf, input int sym,
                              input int zc, input int oc);
        dec_item_t it;
        it = '{hufftw_pkg::CMD_LOAD, idx_t'(idx), leaf, sym_t'(sym), idx_t'(zc), idx_t'(oc),
               sym_t'($urandom_range(0, 255))};
        item_q.push_back(it);
        if (!slot_loaded[idx])
        begin
            slot_loaded[idx] = 1'b1;
            loaded_slots.push_back(idx);
        end
        random_items++;
    endtask

    task automatic queue_code(input int code);
        dec_item_t it;
        it = '{hufftw_pkg::CMD_CODE, idx_t'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
               sym_t'($urandom_range(0, 255)), idx_t'($urandom_range(0, 511)),
               idx_t'($urandom_range(0, 511)), sym_t'(code)};
        item_q.push_back(it);
        random_items++;
    endtask

    task automatic queue_cmd(input logic [hufftw_pkg::CMD_W-1:0] cmd);
        dec_item_t it;
        it = '{cmd, idx_t'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
               sym_t'($urandom_range(0, 255)), idx_t'($urandom_range(0, 511)),
               idx_t'($urandom_range(0, 511)), sym_t'($urandom_range(0, 255))};
        item_q.push_back(it);
        if (cmd != CMD_RSVD)
            random_items++;
    endtask

    // children are loaded before parents, root (slot 0) last
    task automatic queue_tree(input int leaves);
        int slot_of [0:2*MAX_LEAVES-2];
        bit taken [0:hufftw_pkg::TABLE_NODES-1];
        int pool [$];
        int nodes;
        int pick;
        int a;
        int b;
        nodes = 2 * leaves - 1;
        taken[0] = 1'b1;
        for (int k = 0; k < nodes - 1; k++)
        begin
            do
                pick = $urandom_range(1, hufftw_pkg::TABLE_NODES - 1);
            while (taken[pick]);
            taken[pick] = 1'b1;
            slot_of[k]  = pick;
        end
        slot_of[nodes-1] = 0;
        for (int k = 0; k < leaves; k++)
        begin
            pool.push_back(k);
            queue_load(slot_of[k], 1'b1, $urandom_range(0, 255),
                       $urandom_range(0, 511), $urandom_range(0, 511));
        end
        for (int k = leaves; k < nodes; k++)
        begin
            pick = $urandom_range(0, pool.size() - 1);
            a    = pool[pick];
            pool.delete(pick);
            pick = $urandom_range(0, pool.size() - 1);
            b    = pool[pick];
            pool.delete(pick);
            pool.push_back(k);
            queue_load(slot_of[k], 1'b0, $urandom_range(0, 255), slot_of[a], slot_of[b]);
        end
    endtask

    task automatic drain_all();
        do
            @(posedge clk);
        while (item_q.size() != 0 || s_tvalid || sym_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_symbol_count(input logic [hufftw_pkg::COUNT_W-1:0] value);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        count_cfg   = value;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                walk_tree(on_wire);
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (item_q.size() > 0)
                begin
                    on_wire = item_q.pop_front();
                    s_tdata <= {4'b0, on_wire.code_byte, on_wire.one_child, on_wire.zero_child,
                                on_wire.symbol, on_wire.leaf, on_wire.node_index};
                    s_tuser <= on_wire.cmd;
                    offer    = 1'b1;
                    send_gap = no_gaps ? 0 : $urandom_range(0, 4);
                end
            end
            s_tvalid <= offer;
        end
    end

    // receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                rx_wait = no_gaps ? 0 : $urandom_range(0, 4);
            else if (rx_wait > 0)
                rx_wait--;
            m_tready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // long receiver hold-off
    always
    begin
        @(posedge clk);
        if (rx_hold_req)
        begin
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
            rx_hold_req = 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sym_exp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sym_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected transaction: sym %02h last %0d done %0d",
                             m_tdata, m_tlast, m_tuser);
                mismatches++;
            end
            else
            begin
                want = sym_q.pop_front();
                if (m_tdata !== want.sym || m_tlast !== want.last || m_tuser !== want.done)
                begin
                    if (mismatches < 10)
                        $display({"mismatch: exp sym %02h last %0d done %0d, ",
                                  "got sym %02h last %0d done %0d"},
                                 want.sym, want.last, want.done, m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int                             nbytes;
        int                             slot;
        logic [hufftw_pkg::COUNT_W-1:0] count_value;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // count zero: nothing decoded
        set_symbol_count('0);
        queue_load(511, 1'b1, 'hFF, 511, 0);
        queue_load(256, 1'b1, 'h00, 0, 511);
        queue_load(2, 1'b1, 'hA5, 256, 1);
        queue_load(1, 1'b0, 'h00, 256, 2);
        queue_load(0, 1'b0, 'h00, 1, 511);
        queue_cmd(hufftw_pkg::CMD_START);
        queue_code('hFF);
        queue_cmd(CMD_RSVD);

        // full count; inner node turned into a leaf mid-walk, then back
        set_symbol_count('1);
        queue_cmd(hufftw_pkg::CMD_START);
        queue_code('h00);
        queue_code('hFF);
        queue_code('h01);
        queue_load(1, 1'b1, 'h5C, 0, 0);
        queue_code('h33);
        queue_load(1, 1'b0, 'hFF, 256, 0);
        queue_code('hA6);
        queue_cmd(CMD_RSVD);

        // count one: rest of stream ignored
        set_symbol_count(1);
        queue_cmd(hufftw_pkg::CMD_START);
        queue_code('h00);
        queue_code('hFF);

        // root is a leaf
        set_symbol_count(10);
        queue_load(0, 1'b1, 'h3C, $urandom_range(0, 511), $urandom_range(0, 511));
        queue_cmd(hufftw_pkg::CMD_START);
        queue_code('h5A);
        queue_code('hC3);

        random_items = 0;
        for (int p = 0; random_items < RANDOM_ITEMS; p++)
        begin
            case (p % 6)
                0: count_value = '1;
                1: count_value = '0;
                2: count_value = 1;
                3: count_value = $urandom;
                default: count_value = $urandom_range(2, 48);
            endcase
            set_symbol_count(count_value);
            no_gaps = (p % 4 == 3);
            if (p == HOLD_PHASE)
                queue_tree(2);
            else if (p == 0 || $urandom_range(0, 9) < 6)
                queue_tree((p % 7 == 4) ? 1 : $urandom_range(2, MAX_LEAVES));
            queue_cmd(hufftw_pkg::CMD_START);
            if (p == HOLD_PHASE)
                rx_hold_req = 1'b1;
            nbytes = (p == HOLD_PHASE) ? 30 : $urandom_range(4, 14);
            repeat (nbytes)
            begin
                case ($urandom_range(0, 19))
                    0: queue_cmd(CMD_RSVD);
                    1: queue_cmd(hufftw_pkg::CMD_START);
                    2:
                    begin
                        // random rewrite; inner children point only at loaded slots
                        slot = $urandom_range(0, hufftw_pkg::TABLE_NODES - 1);
                        if ($urandom_range(0, 1) == 1)
                            queue_load(slot, 1'b1, $urandom_range(0, 255),
                                       $urandom_range(0, 511), $urandom_range(0, 511));
                        else
                            queue_load(slot, 1'b0, $urandom_range(0, 255),
                                loaded_slots[$urandom_range(0, loaded_slots.size() - 1)],
                                loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
                    end
                    default: queue_code($urandom_range(0, 255));
                endcase
            end
        end

        drain_all();
        if (mismatches == 0 && sym_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
src/hufftw_pkg.sv
src/huffman_tree_walk_decoder.sv
src/hufftw_checker.sv
test/testbench.sv
